/* rtl/tbw_pkg.sv */
// Shared types and fixed widths for the barycentric weight pipeline.
// No dependencies; imported by every module in rtl/.
package tbw_pkg;

    localparam int VERT_W   = 16;  // vertex coordinate width
    localparam int PT_W     = 12;  // pixel point width
    localparam int OUT_W    = 21;  // weight output width
    localparam int ACC_W    = 64;  // signed working width of the weight math
    localparam int QCAP_LOG = 61;  // quotient magnitude clamps at 2^QCAP_LOG

    // Control that rides alongside each transaction through the pipeline
    typedef struct packed {
        logic valid;
        logic degen;   // doubled area is zero
        logic neg_a;   // w1 quotient is negative
        logic neg_b;   // w2 quotient is negative
    } t_flags;

endpackage

/* rtl/tbw_front.sv */
// Front end: edge vectors, six cross-product multiplies, cross sums, magnitudes.
// Four register stages. Depends on tbw_pkg.
module tbw_front #(
    parameter  int COORD_FRAC_BITS = 4,
    localparam int A_W   = tbw_pkg::VERT_W + 1,
    localparam int PS_W  = tbw_pkg::PT_W + COORD_FRAC_BITS,
    localparam int C_W   = ((PS_W > tbw_pkg::VERT_W) ? PS_W : tbw_pkg::VERT_W) + 1,
    localparam int DEN_W = 2 * A_W + 1,
    localparam int NUM_W = C_W + A_W + 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex0_x,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex0_y,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex1_x,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex1_y,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex2_x,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex2_y,
    input  logic signed [tbw_pkg::PT_W-1:0]    i_point_x,
    input  logic signed [tbw_pkg::PT_W-1:0]    i_point_y,
    output tbw_pkg::t_flags                    o_flags,
    output logic [DEN_W-1:0]                   o_den_mag,
    output logic [NUM_W-1:0]                   o_num_a_mag,
    output logic [NUM_W-1:0]                   o_num_b_mag
);
    import tbw_pkg::*;

    localparam int PD_W = 2 * A_W;
    localparam int PN_W = C_W + A_W;

    logic signed [PS_W-1:0] w_px, w_py;

    // stage 1: edge vectors
    logic                  r_v1;
    logic signed [A_W-1:0] r_ax, r_ay, r_bx, r_by, n_ax, n_ay, n_bx, n_by;
    logic signed [C_W-1:0] r_cx, r_cy, n_cx, n_cy;

    // stage 2: products
    logic                   r_v2;
    logic signed [PD_W-1:0] r_pd0, r_pd1, n_pd0, n_pd1;
    logic signed [PN_W-1:0] r_pa0, r_pa1, r_pb0, r_pb1, n_pa0, n_pa1, n_pb0, n_pb1;

    // stage 3: cross products
    logic                    r_v3;
    logic signed [DEN_W-1:0] r_den, n_den;
    logic signed [NUM_W-1:0] r_num_a, r_num_b, n_num_a, n_num_b;

    // stage 4: sign and magnitude split
    t_flags            r_flags, n_flags;
    logic [DEN_W-1:0]  r_den_mag, n_den_mag;
    logic [NUM_W-1:0]  r_num_a_mag, r_num_b_mag, n_num_a_mag, n_num_b_mag;

    always_comb begin
        w_px = PS_W'(i_point_x) <<< COORD_FRAC_BITS;
        w_py = PS_W'(i_point_y) <<< COORD_FRAC_BITS;
        n_ax = A_W'(i_vertex1_x) - A_W'(i_vertex0_x);
        n_ay = A_W'(i_vertex1_y) - A_W'(i_vertex0_y);
        n_bx = A_W'(i_vertex2_x) - A_W'(i_vertex0_x);
        n_by = A_W'(i_vertex2_y) - A_W'(i_vertex0_y);
        n_cx = C_W'(w_px) - C_W'(i_vertex0_x);
        n_cy = C_W'(w_py) - C_W'(i_vertex0_y);
    end

    always_comb begin
        n_pd0 = PD_W'(r_ax) * PD_W'(r_by);
        n_pd1 = PD_W'(r_ay) * PD_W'(r_bx);
        n_pa0 = PN_W'(r_cx) * PN_W'(r_by);
        n_pa1 = PN_W'(r_cy) * PN_W'(r_bx);
        n_pb0 = PN_W'(r_ax) * PN_W'(r_cy);
        n_pb1 = PN_W'(r_ay) * PN_W'(r_cx);
    end

    always_comb begin
        n_den   = DEN_W'(r_pd0) - DEN_W'(r_pd1);
        n_num_a = NUM_W'(r_pa0) - NUM_W'(r_pa1);
        n_num_b = NUM_W'(r_pb0) - NUM_W'(r_pb1);
    end

    always_comb begin
        n_flags.valid = r_v3;
        n_flags.degen = (r_den == '0);
        n_flags.neg_a = r_num_a[NUM_W-1] ^ r_den[DEN_W-1];
        n_flags.neg_b = r_num_b[NUM_W-1] ^ r_den[DEN_W-1];
        n_den_mag     = r_den[DEN_W-1]     ? DEN_W'(-r_den)     : DEN_W'(r_den);
        n_num_a_mag   = r_num_a[NUM_W-1]   ? NUM_W'(-r_num_a)   : NUM_W'(r_num_a);
        n_num_b_mag   = r_num_b[NUM_W-1]   ? NUM_W'(-r_num_b)   : NUM_W'(r_num_b);
    end

    // only the valid bits see reset; data registers load every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_flags.valid <= 1'b0;
        end else begin
            r_v1          <= i_valid;
            r_v2          <= r_v1;
            r_v3          <= r_v2;
            r_flags.valid <= n_flags.valid;
        end
        r_ax          <= n_ax;
        r_ay          <= n_ay;
        r_bx          <= n_bx;
        r_by          <= n_by;
        r_cx          <= n_cx;
        r_cy          <= n_cy;
        r_pd0         <= n_pd0;
        r_pd1         <= n_pd1;
        r_pa0         <= n_pa0;
        r_pa1         <= n_pa1;
        r_pb0         <= n_pb0;
        r_pb1         <= n_pb1;
        r_den         <= n_den;
        r_num_a       <= n_num_a;
        r_num_b       <= n_num_b;
        r_flags.degen <= n_flags.degen;
        r_flags.neg_a <= n_flags.neg_a;
        r_flags.neg_b <= n_flags.neg_b;
        r_den_mag     <= n_den_mag;
        r_num_a_mag   <= n_num_a_mag;
        r_num_b_mag   <= n_num_b_mag;
    end

    assign o_flags     = r_flags;
    assign o_den_mag   = r_den_mag;
    assign o_num_a_mag = r_num_a_mag;
    assign o_num_b_mag = r_num_b_mag;

endmodule

/* rtl/tbw_div_step.sv */
// One restoring-division step for two dividends sharing a divisor.
// Produces one quotient bit per lane per cycle. Depends on tbw_pkg.
module tbw_div_step #(
    parameter int N_W = 35,
    parameter int D_W = 35,
    parameter int Q_W = 51
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tbw_pkg::t_flags  i_flags,
    input  logic [D_W-1:0]   i_den,
    input  logic [N_W-1:0]   i_num_a,
    input  logic [N_W-1:0]   i_num_b,
    input  logic [D_W-1:0]   i_rem_a,
    input  logic [D_W-1:0]   i_rem_b,
    input  logic [Q_W-1:0]   i_quo_a,
    input  logic [Q_W-1:0]   i_quo_b,
    output tbw_pkg::t_flags  o_flags,
    output logic [D_W-1:0]   o_den,
    output logic [N_W-1:0]   o_num_a,
    output logic [N_W-1:0]   o_num_b,
    output logic [D_W-1:0]   o_rem_a,
    output logic [D_W-1:0]   o_rem_b,
    output logic [Q_W-1:0]   o_quo_a,
    output logic [Q_W-1:0]   o_quo_b
);
    import tbw_pkg::*;

    logic [D_W:0]   w_trial_a, w_trial_b, w_diff_a, w_diff_b;
    logic           w_ge_a, w_ge_b;
    logic [D_W-1:0] n_rem_a, n_rem_b;
    logic [Q_W-1:0] n_quo_a, n_quo_b;

    t_flags         r_flags;
    logic [D_W-1:0] r_den, r_rem_a, r_rem_b;
    logic [N_W-1:0] r_num_a, r_num_b;
    logic [Q_W-1:0] r_quo_a, r_quo_b;

    // remainder stays below the divisor, so trial < 2*den and the borrow decides
    always_comb begin
        w_trial_a = {i_rem_a, i_num_a[N_W-1]};
        w_trial_b = {i_rem_b, i_num_b[N_W-1]};
        w_diff_a  = w_trial_a - {1'b0, i_den};
        w_diff_b  = w_trial_b - {1'b0, i_den};
        w_ge_a    = ~w_diff_a[D_W];
        w_ge_b    = ~w_diff_b[D_W];
        n_rem_a   = w_ge_a ? w_diff_a[D_W-1:0] : w_trial_a[D_W-1:0];
        n_rem_b   = w_ge_b ? w_diff_b[D_W-1:0] : w_trial_b[D_W-1:0];
        n_quo_a   = {i_quo_a[Q_W-2:0], w_ge_a};
        n_quo_b   = {i_quo_b[Q_W-2:0], w_ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.valid <= 1'b0;
        end else begin
            r_flags.valid <= i_flags.valid;
        end
        r_flags.degen <= i_flags.degen;
        r_flags.neg_a <= i_flags.neg_a;
        r_flags.neg_b <= i_flags.neg_b;
        r_den         <= i_den;
        r_num_a       <= i_num_a << 1;
        r_num_b       <= i_num_b << 1;
        r_rem_a       <= n_rem_a;
        r_rem_b       <= n_rem_b;
        r_quo_a       <= n_quo_a;
        r_quo_b       <= n_quo_b;
    end

    assign o_flags = r_flags;
    assign o_den   = r_den;
    assign o_num_a = r_num_a;
    assign o_num_b = r_num_b;
    assign o_rem_a = r_rem_a;
    assign o_rem_b = r_rem_b;
    assign o_quo_a = r_quo_a;
    assign o_quo_b = r_quo_b;

endmodule

/* rtl/tbw_divider.sv */
// Pipelined fixed-point divider: |num| * 2^F_W / |den|, one quotient bit per stage.
// Chains Q_W tbw_div_step instances. Depends on tbw_pkg, tbw_div_step.
module tbw_divider #(
    parameter  int N_W = 35,
    parameter  int D_W = 35,
    parameter  int F_W = 16,
    localparam int Q_W = N_W + F_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tbw_pkg::t_flags  i_flags,
    input  logic [D_W-1:0]   i_den,
    input  logic [N_W-1:0]   i_num_a,
    input  logic [N_W-1:0]   i_num_b,
    output tbw_pkg::t_flags  o_flags,
    output logic [Q_W-1:0]   o_quo_a,
    output logic [Q_W-1:0]   o_quo_b
);
    import tbw_pkg::*;

    // element k feeds step k; the numerator shifts out MSB first, then zeros
    wire t_flags       w_flags [Q_W+1];
    wire [D_W-1:0]     w_den   [Q_W+1];
    wire [N_W-1:0]     w_num_a [Q_W+1];
    wire [N_W-1:0]     w_num_b [Q_W+1];
    wire [D_W-1:0]     w_rem_a [Q_W+1];
    wire [D_W-1:0]     w_rem_b [Q_W+1];
    wire [Q_W-1:0]     w_quo_a [Q_W+1];
    wire [Q_W-1:0]     w_quo_b [Q_W+1];

    assign w_flags[0] = i_flags;
    assign w_den[0]   = i_den;
    assign w_num_a[0] = i_num_a;
    assign w_num_b[0] = i_num_b;
    assign w_rem_a[0] = '0;
    assign w_rem_b[0] = '0;
    assign w_quo_a[0] = '0;
    assign w_quo_b[0] = '0;

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        tbw_div_step #(
            .N_W (N_W),
            .D_W (D_W),
            .Q_W (Q_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flags (w_flags[k]),
            .i_den   (w_den[k]),
            .i_num_a (w_num_a[k]),
            .i_num_b (w_num_b[k]),
            .i_rem_a (w_rem_a[k]),
            .i_rem_b (w_rem_b[k]),
            .i_quo_a (w_quo_a[k]),
            .i_quo_b (w_quo_b[k]),
            .o_flags (w_flags[k+1]),
            .o_den   (w_den[k+1]),
            .o_num_a (w_num_a[k+1]),
            .o_num_b (w_num_b[k+1]),
            .o_rem_a (w_rem_a[k+1]),
            .o_rem_b (w_rem_b[k+1]),
            .o_quo_a (w_quo_a[k+1]),
            .o_quo_b (w_quo_b[k+1])
        );
    end

    assign o_flags = w_flags[Q_W];
    assign o_quo_a = w_quo_a[Q_W];
    assign o_quo_b = w_quo_b[Q_W];

endmodule

/* rtl/tbw_combine.sv */
// Back end: quotient clamp and sign, w0 = 1 - w1 - w2, saturation, output registers.
// Three register stages; degenerate results come out as zero weights. Depends on tbw_pkg.
module tbw_combine #(
    parameter int WEIGHT_FRAC_BITS = 16,
    parameter int Q_W              = 51
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tbw_pkg::t_flags                     i_flags,
    input  logic [Q_W-1:0]                      i_quo_a,
    input  logic [Q_W-1:0]                      i_quo_b,
    output logic                                o_done,
    output logic signed [tbw_pkg::OUT_W-1:0]    o_weight_0,
    output logic signed [tbw_pkg::OUT_W-1:0]    o_weight_1,
    output logic signed [tbw_pkg::OUT_W-1:0]    o_weight_2,
    output logic                                o_degenerate
);
    import tbw_pkg::*;

    localparam logic [ACC_W-1:0]        CAP    = ACC_W'(1) << QCAP_LOG;
    localparam logic signed [ACC_W-1:0] LIM_HI = (ACC_W'(64'sd1) <<< (OUT_W - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI - 64'sd1;
    localparam logic signed [ACC_W-1:0] ONE    = ACC_W'(64'sd1) <<< WEIGHT_FRAC_BITS;

    function automatic logic signed [ACC_W-1:0] to_weight(input logic [Q_W-1:0] quo,
                                                          input logic neg);
        logic [ACC_W-1:0] q64;
        logic [ACC_W-1:0] mag;
        begin
            q64 = ACC_W'(quo);
            mag = (q64 >= CAP) ? CAP : q64;
            return neg ? -$signed(mag) : $signed(mag);
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        begin
            c = v;
            if (v > LIM_HI) begin
                c = LIM_HI;
            end else if (v < LIM_LO) begin
                c = LIM_LO;
            end
            return c[OUT_W-1:0];
        end
    endfunction

    // stage 1
    logic                    r_v1, r_dg1;
    logic signed [ACC_W-1:0] r_w1_1, r_w2_1;
    // stage 2
    logic                    r_v2, r_dg2;
    logic signed [ACC_W-1:0] r_w0_2, r_w1_2, r_w2_2, n_w0_2;
    // stage 3 (outputs)
    logic                    r_done, r_degen;
    logic signed [OUT_W-1:0] r_wt0, r_wt1, r_wt2, n_wt0, n_wt1, n_wt2;

    always_comb begin
        n_w0_2 = ONE - r_w1_1 - r_w2_1;
    end

    always_comb begin
        if (r_dg2) begin
            n_wt0 = '0;
            n_wt1 = '0;
            n_wt2 = '0;
        end else begin
            n_wt0 = sat_out(r_w0_2);
            n_wt1 = sat_out(r_w1_2);
            n_wt2 = sat_out(r_w2_2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_flags.valid;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dg1   <= i_flags.degen;
        r_w1_1  <= to_weight(i_quo_a, i_flags.neg_a);
        r_w2_1  <= to_weight(i_quo_b, i_flags.neg_b);
        r_dg2   <= r_dg1;
        r_w0_2  <= n_w0_2;
        r_w1_2  <= r_w1_1;
        r_w2_2  <= r_w2_1;
        r_degen <= r_dg2;
        r_wt0   <= n_wt0;
        r_wt1   <= n_wt1;
        r_wt2   <= n_wt2;
    end

    assign o_done       = r_done;
    assign o_degenerate = r_degen;
    assign o_weight_0   = r_wt0;
    assign o_weight_1   = r_wt1;
    assign o_weight_2   = r_wt2;

endmodule

/* rtl/triangle_barycentric_weights.sv */
// Top level: barycentric weights of a pixel point in a 2D fixed-point triangle.
// Depends on tbw_pkg, tbw_front, tbw_divider (tbw_div_step), tbw_combine.
//
//  channel   handshake        payload
//  --------  ---------------  --------------------------------------------------
//  input     start / busy     i_vertex{0,1,2}_{x,y}, i_point_x, i_point_y
//  result    o_done (strobe)  o_weight_0, o_weight_1, o_weight_2, o_degenerate
//
//  One transaction per cycle; busy stays low. A transaction passes the front end, the
//  divider (Q_W = numerator width + WEIGHT_FRAC_BITS quotient bits, one per divider
//  stage) and the back end. The divider chain sets the latency.
//  Reset clears only the valid bits; nothing in flight survives it.
//  No stalls: the result strobe lasts one cycle and is never held off.
module triangle_barycentric_weights #(
    parameter int COORD_FRAC_BITS  = 4,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex0_x,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex0_y,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex1_x,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex1_y,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex2_x,
    input  logic signed [tbw_pkg::VERT_W-1:0]  i_vertex2_y,
    input  logic signed [tbw_pkg::PT_W-1:0]    i_point_x,
    input  logic signed [tbw_pkg::PT_W-1:0]    i_point_y,
    output logic                               o_done,
    output logic signed [tbw_pkg::OUT_W-1:0]   o_weight_0,
    output logic signed [tbw_pkg::OUT_W-1:0]   o_weight_1,
    output logic signed [tbw_pkg::OUT_W-1:0]   o_weight_2,
    output logic                               o_degenerate
);
    import tbw_pkg::*;

    localparam int A_W   = VERT_W + 1;
    localparam int PS_W  = PT_W + COORD_FRAC_BITS;
    localparam int C_W   = ((PS_W > VERT_W) ? PS_W : VERT_W) + 1;
    localparam int DEN_W = 2 * A_W + 1;
    localparam int NUM_W = C_W + A_W + 1;
    localparam int Q_W   = NUM_W + WEIGHT_FRAC_BITS;
    localparam int LAT   = 4 + Q_W + 3;

    localparam logic signed [OUT_W-1:0] W_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] W_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    logic             w_accept;
    t_flags           w_fr_flags, w_dv_flags;
    logic [DEN_W-1:0] w_den_mag;
    logic [NUM_W-1:0] w_num_a_mag, w_num_b_mag;
    logic [Q_W-1:0]   w_quo_a, w_quo_b;

    // fully pipelined, never refuses a transaction
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    tbw_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_vertex0_x (i_vertex0_x),
        .i_vertex0_y (i_vertex0_y),
        .i_vertex1_x (i_vertex1_x),
        .i_vertex1_y (i_vertex1_y),
        .i_vertex2_x (i_vertex2_x),
        .i_vertex2_y (i_vertex2_y),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .o_flags     (w_fr_flags),
        .o_den_mag   (w_den_mag),
        .o_num_a_mag (w_num_a_mag),
        .o_num_b_mag (w_num_b_mag)
    );

    tbw_divider #(
        .N_W (NUM_W),
        .D_W (DEN_W),
        .F_W (WEIGHT_FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_fr_flags),
        .i_den   (w_den_mag),
        .i_num_a (w_num_a_mag),
        .i_num_b (w_num_b_mag),
        .o_flags (w_dv_flags),
        .o_quo_a (w_quo_a),
        .o_quo_b (w_quo_b)
    );

    tbw_combine #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .Q_W              (Q_W)
    ) u_combine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_flags      (w_dv_flags),
        .i_quo_a      (w_quo_a),
        .i_quo_b      (w_quo_b),
        .o_done       (o_done),
        .o_weight_0   (o_weight_0),
        .o_weight_1   (o_weight_1),
        .o_weight_2   (o_weight_2),
        .o_degenerate (o_degenerate)
    );

`ifndef SYNTHESIS
    // every accepted transaction is followed by its result strobe
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_done)
        else $error("result missing after accepted transaction");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without a matching transaction");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_degenerate |->
            (o_weight_0 == '0) && (o_weight_1 == '0) && (o_weight_2 == '0))
        else $error("degenerate result with nonzero weights");

    // for a non-degenerate triangle without saturation the weights sum to exactly one
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_degenerate
            && o_weight_0 != W_MAX && o_weight_0 != W_MIN
            && o_weight_1 != W_MAX && o_weight_1 != W_MIN
            && o_weight_2 != W_MAX && o_weight_2 != W_MIN
        |-> (32'(o_weight_0) + 32'(o_weight_1) + 32'(o_weight_2))
            == (32'sd1 <<< WEIGHT_FRAC_BITS))
        else $error("weights do not sum to one");
`endif

endmodule
